// ===== hdl/i2cmt_pkg.sv =====
// shared types and constants of the i2c master transaction unit
package i2cmt_pkg;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [7:0] TPP_RESET = 8'd5;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        PH_IDLE, S_SDA1, S_SCL1, S_SDA0, S_SCL0,
        W_SCL0, W_SDA, W_SCL1, W_END,
        A_SCL0, A_SCL1, A_WAIT, A_SCL0B,
        R_SCL0A, R_BSCL0, R_BSCL1, R_END,
        K_SCL0, K_SDA, K_SCL1,
        P_SDA0, P_SCL1, P_SDA1
    } phase_t;

    // result of one tick
    typedef struct packed {
        logic       success;
        logic       done_res;
        logic       busy_res;
        logic       byte_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

// ===== hdl/i2cmt_seq.sv =====
// phase sequencer: bus state, hold timing and per-tick result
module i2cmt_seq
    import i2cmt_pkg::*;
#(
    parameter int MAX_BYTES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [1:0] func,
    input  logic [6:0] device_address,
    input  logic [8:0] byte_count,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    input  logic [7:0] ticks_per_phase,
    output result_t    res
);

    localparam int BL_W = $clog2(MAX_BYTES + 1);

    phase_t            ph_reg, ph_next, ent_ph;
    logic              ent;
    logic [7:0]        hc_reg, hc_next, hc_dec, tpp_eff;
    logic [2:0]        bc_reg, bc_next;
    logic [BL_W-1:0]   bl_reg, bl_next, bl_dec, bl_cmd;
    logic [7:0]        sb_reg, sb_next;
    logic              rd_reg, rd_next;
    logic              af_reg, af_next;
    logic              ia_reg, ia_next;
    logic              scl_reg, scl_next, sda_reg, sda_next, drv_reg, drv_next;
    logic [31:0]       cnt32;
    logic              o_rv, o_bt, o_done, o_succ;
    logic [7:0]        o_rd;

    assign tpp_eff = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
    assign hc_dec  = (hc_reg != 8'd0) ? hc_reg - 8'd1 : hc_reg;
    assign bl_dec  = (bl_reg != '0) ? bl_reg - BL_W'(1) : bl_reg;

    // byte count with zero taken as one and saturation at the maximum
    always_comb
    begin
        cnt32 = {23'd0, byte_count};
        if (cnt32 == 32'd0)
        begin
            cnt32 = 32'd1;
        end
        if (cnt32 > 32'(MAX_BYTES))
        begin
            cnt32 = 32'(MAX_BYTES);
        end
        bl_cmd = cnt32[BL_W-1:0];
    end

    // next state
    always_comb
    begin
        ph_next = ph_reg;
        hc_next = hc_reg;
        bc_next = bc_reg;
        bl_next = bl_reg;
        sb_next = sb_reg;
        rd_next = rd_reg;
        af_next = af_reg;
        ia_next = ia_reg;
        ent     = 1'b0;
        ent_ph  = ph_reg;
        o_rv    = 1'b0;
        o_bt    = 1'b0;
        o_done  = 1'b0;
        o_succ  = 1'b0;
        o_rd    = 8'd0;
        if (ph_reg == PH_IDLE)
        begin
            if (func == FUNC_READ || func == FUNC_WRITE)
            begin
                bl_next = bl_cmd;
                rd_next = (func == FUNC_READ);
                ia_next = 1'b1;
                af_next = 1'b0;
                bc_next = 3'd0;
                sb_next = {device_address, func == FUNC_READ};
                ent     = 1'b1;
                ent_ph  = S_SDA1;
            end
        end
        else
        begin
            hc_next = hc_dec;
            if (hc_dec == 8'd0)
            begin
                ent = 1'b1;
                case (ph_reg)
                    S_SDA1:  ent_ph = S_SCL1;
                    S_SCL1:  ent_ph = S_SDA0;
                    S_SDA0:  ent_ph = S_SCL0;
                    S_SCL0:
                    begin
                        bc_next = 3'd0;
                        ent_ph  = W_SCL0;
                    end
                    W_SCL0:  ent_ph = W_SDA;
                    W_SDA:   ent_ph = W_SCL1;
                    W_SCL1:
                    begin
                        sb_next = {sb_reg[6:0], 1'b0};
                        if (bc_reg == 3'd7)
                        begin
                            bc_next = 3'd0;
                            ent_ph  = W_END;
                        end
                        else
                        begin
                            bc_next = bc_reg + 3'd1;
                            ent_ph  = W_SCL0;
                        end
                    end
                    W_END:   ent_ph = A_SCL0;
                    A_SCL0:  ent_ph = A_SCL1;
                    A_SCL1:  ent_ph = A_WAIT;
                    A_WAIT:
                    begin
                        af_next = sda_in;
                        ent_ph  = A_SCL0B;
                    end
                    A_SCL0B:
                    begin
                        // address ack, last write byte (ack ignored), or middle write byte
                        if (ia_reg && af_reg)
                        begin
                            ent_ph = P_SDA0;
                        end
                        else if (ia_reg && rd_reg)
                        begin
                            ia_next = 1'b0;
                            ent_ph  = R_SCL0A;
                        end
                        else if (!ia_reg && bl_reg == '0)
                        begin
                            af_next = 1'b0;
                            ent_ph  = P_SDA0;
                        end
                        else if (!ia_reg && af_reg)
                        begin
                            ent_ph = P_SDA0;
                        end
                        else
                        begin
                            ia_next = 1'b0;
                            sb_next = write_data;
                            bl_next = bl_dec;
                            bc_next = 3'd0;
                            o_bt    = 1'b1;
                            ent_ph  = W_SCL0;
                        end
                    end
                    R_SCL0A:
                    begin
                        bc_next = 3'd0;
                        sb_next = 8'd0;
                        ent_ph  = R_BSCL0;
                    end
                    R_BSCL0: ent_ph = R_BSCL1;
                    R_BSCL1:
                    begin
                        sb_next = {sb_reg[6:0], sda_in};
                        if (bc_reg == 3'd7)
                        begin
                            bc_next = 3'd0;
                            ent_ph  = R_END;
                        end
                        else
                        begin
                            bc_next = bc_reg + 3'd1;
                            ent_ph  = R_BSCL0;
                        end
                    end
                    R_END:
                    begin
                        o_rd    = sb_reg;
                        o_rv    = 1'b1;
                        bl_next = bl_dec;
                        ent_ph  = K_SCL0;
                    end
                    K_SCL0:  ent_ph = K_SDA;
                    K_SDA:   ent_ph = K_SCL1;
                    K_SCL1:  ent_ph = (bl_reg != '0) ? R_SCL0A : P_SDA0;
                    P_SDA0:  ent_ph = P_SCL1;
                    P_SCL1:  ent_ph = P_SDA1;
                    P_SDA1:
                    begin
                        ent     = 1'b0;
                        ph_next = PH_IDLE;
                        hc_next = 8'd0;
                        o_done  = 1'b1;
                        o_succ  = !af_reg;
                    end
                    default:
                    begin
                        ent     = 1'b0;
                        ph_next = PH_IDLE;
                    end
                endcase
            end
        end
        if (ent)
        begin
            ph_next = ent_ph;
            hc_next = tpp_eff;
        end
    end

    // line levels set on entry to a phase
    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        drv_next = drv_reg;
        if (ent)
        begin
            case (ent_ph)
                S_SDA1:  sda_next = 1'b1;
                S_SCL1:  scl_next = 1'b1;
                S_SDA0:  sda_next = 1'b0;
                S_SCL0:  scl_next = 1'b0;
                W_SCL0:
                begin
                    scl_next = 1'b0;
                    drv_next = 1'b1;
                end
                W_SDA:   sda_next = sb_reg[7];
                W_SCL1:  scl_next = 1'b1;
                W_END:   scl_next = 1'b0;
                A_SCL0:  scl_next = 1'b0;
                A_SCL1:
                begin
                    drv_next = 1'b0;
                    scl_next = 1'b1;
                end
                A_SCL0B: scl_next = 1'b0;
                R_SCL0A:
                begin
                    scl_next = 1'b0;
                    drv_next = 1'b1;
                end
                R_BSCL0:
                begin
                    drv_next = 1'b0;
                    scl_next = 1'b0;
                end
                R_BSCL1: scl_next = 1'b1;
                R_END:   scl_next = 1'b0;
                K_SCL0:
                begin
                    scl_next = 1'b0;
                    drv_next = 1'b1;
                end
                K_SDA:   sda_next = (bl_reg == '0);
                K_SCL1:  scl_next = 1'b1;
                P_SDA0:
                begin
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                end
                P_SCL1:  scl_next = 1'b1;
                P_SDA1:  sda_next = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.success    = o_succ;
        res.done_res   = o_done;
        res.busy_res   = (ph_next != PH_IDLE);
        res.byte_taken = o_bt;
        res.read_valid = o_rv;
        res.read_data  = o_rd;
        res.sda_drive  = drv_next;
        res.sda_level  = sda_next;
        res.scl_level  = scl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_IDLE;
            hc_reg  <= 8'd0;
            bc_reg  <= 3'd0;
            bl_reg  <= '0;
            sb_reg  <= 8'd0;
            rd_reg  <= 1'b0;
            af_reg  <= 1'b0;
            ia_reg  <= 1'b0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            drv_reg <= 1'b1;
        end
        else if (step)
        begin
            ph_reg  <= ph_next;
            hc_reg  <= hc_next;
            bc_reg  <= bc_next;
            bl_reg  <= bl_next;
            sb_reg  <= sb_next;
            rd_reg  <= rd_next;
            af_reg  <= af_next;
            ia_reg  <= ia_next;
            scl_reg <= scl_next;
            sda_reg <= sda_next;
            drv_reg <= drv_next;
        end
    end

endmodule

// ===== hdl/i2c_master_transaction_unit.sv =====
// top level of the i2c master transaction unit
//
// Each input item is one bus tick and produces exactly one result item.
// The block takes one item per clock cycle: the tick is worked out in a
// single pass of logic from the phase registers, and its result lands in
// an output register, so an item is accepted whenever that register is
// empty or is being taken in the same cycle. While idle, a tick with
// tuser set to read or write starts a transaction (start, address plus
// R/W bit, data bytes MSB first with ack handling, stop); other ticks and
// commands while busy only advance the bus. Each pin level is held for
// ticks_per_phase ticks (0 acts as 1, reset value 5); the ack check holds
// SCL high for one extra hold period and sda_in is sampled on the last
// tick of an SCL-high hold. Write bytes are taken from write_data on the
// tick whose result shows byte_taken. A missing ack after the address or
// after a byte that is not the last one ends the transaction with stop
// and success low on the done tick. Byte counts of zero act as one and
// counts above MAX_BYTES saturate. The user must write ticks_per_phase
// only while the block is idle; the block itself does not enforce this.
module i2c_master_transaction_unit
    import i2cmt_pkg::*;
#(
    parameter int MAX_BYTES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write, ticks_per_phase
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // device_address[6:0], byte_count[15:7], write_data[23:16], sda_in[24], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scl_level[0], sda_level[1], sda_drive[2], read_data[10:3], read_valid[11],
    // byte_taken[12], busy_res[13], done_res[14], success[15]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [7:0] tpp_val_reg;
    logic       accept;
    logic       out_valid_reg, out_valid_next;
    result_t    res, out_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpp_val_reg <= TPP_RESET;
        end
        else if (cfg_wr_en)
        begin
            tpp_val_reg <= cfg_wr_data;
        end
    end

    // an item goes in when the output register is empty or frees up this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2cmt_seq #(
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (accept),
        .func            (s_tuser[1:0]),
        .device_address  (s_tdata[6:0]),
        .byte_count      (s_tdata[15:7]),
        .write_data      (s_tdata[23:16]),
        .sda_in          (s_tdata[24]),
        .ticks_per_phase (tpp_val_reg),
        .res             (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== hdl/i2cmt_checker.sv =====
// port-level checks of the i2c master transaction unit
module i2cmt_checker
    import i2cmt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side never blocked while output register is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // done tick reports not busy, success only with done
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[14] && m_tdata[13]) && (m_tdata[14] || !m_tdata[15]))
        else $error("done or success inconsistent");

    // a read byte and a taken write byte never share a tick, and both need busy
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11] || m_tdata[12]) |-> !(m_tdata[11] && m_tdata[12]) && m_tdata[13])
        else $error("read and write byte events clash");

endmodule

bind i2c_master_transaction_unit i2cmt_checker u_i2cmt_checker (.*);
